// ----- sv/s2rgb_pkg.sv -----
// Shared types and constants for the scalar-to-RGB colour map pipeline.
package s2rgb_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF  = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned RANGE_HIGH_RESET  = 65536;

  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_LOW     = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_HIGH    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLORMAP_MODE = 2'd2;

  typedef enum logic [1:0] {
    MODE_JET  = 2'd0,
    MODE_HOT  = 2'd1,
    MODE_GRAY = 2'd2
  } s2rgb_mode_e;

  localparam int unsigned NUM_CHAN = 3;
  localparam int unsigned CH_R     = 0;
  localparam int unsigned CH_G     = 1;
  localparam int unsigned CH_B     = 2;

  // floor(z / 666) = (z * HOT_RECIP) >> HOT_SHIFT, exact for z below 2^HOT_Z_WIDTH
  localparam int unsigned HOT_RECIP       = 403057;
  localparam int unsigned HOT_RECIP_WIDTH = 19;
  localparam int unsigned HOT_SHIFT       = 28;
  localparam int unsigned HOT_Z_WIDTH     = 18;

  typedef struct packed {
    logic valid;
    logic black;
    logic sat_lo;
    logic sat_hi;
  } s2rgb_tag_t;

endpackage

// ----- sv/s2rgb_div.sv -----
// Pipelined restoring divider giving the rounded, clamped fraction t.
module s2rgb_div import s2rgb_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [SAMPLE_WIDTH-1:0]  span_i,
  input  s2rgb_tag_t               tag_i,
  input  logic [SAMPLE_WIDTH-1:0]  rem_i,
  output s2rgb_tag_t               tag_o,
  output logic [FRACTION_BITS:0]   t_o
);

  localparam int unsigned W = SAMPLE_WIDTH;
  localparam int unsigned F = FRACTION_BITS;

  logic [W-1:0]  rem_q    [F];
  logic [F-1:0]  quo_q    [F];
  s2rgb_tag_t    tag_q    [F];
  logic [W-1:0]  rem_prev [F];
  logic [F-1:0]  quo_prev [F];
  s2rgb_tag_t    tag_prev [F];
  logic [W:0]    rem_sh   [F];
  logic [W-1:0]  rem_d    [F];
  logic [F-1:0]  quo_d    [F];
  logic [F-1:0]  take;

  logic [W:0]    last_sh;
  logic          last_take;
  logic [F:0]    t_d;
  logic [F:0]    t_q;
  s2rgb_tag_t    tag_out_q;

  for (genvar i = 0; i < F; i++) begin : g_step
    if (i == 0) begin : g_head
      assign rem_prev[i] = rem_i;
      assign quo_prev[i] = '0;
      assign tag_prev[i] = tag_i;
    end else begin : g_body
      assign rem_prev[i] = rem_q[i-1];
      assign quo_prev[i] = quo_q[i-1];
      assign tag_prev[i] = tag_q[i-1];
    end
    assign rem_sh[i] = {rem_prev[i], 1'b0};
    assign take[i]   = rem_sh[i] >= {1'b0, span_i};
    assign rem_d[i]  = take[i] ? W'(rem_sh[i] - {1'b0, span_i}) : rem_sh[i][W-1:0];
    assign quo_d[i]  = {quo_prev[i][F-2:0], take[i]};
  end

  // round-half-up step, then clamp for samples outside the range
  assign last_sh   = {rem_q[F-1], 1'b0};
  assign last_take = last_sh >= {1'b0, span_i};

  always_comb begin
    priority if (tag_q[F-1].sat_lo) begin
      t_d = '0;
    end else if (tag_q[F-1].sat_hi) begin
      t_d = (F+1)'(1) << F;
    end else begin
      t_d = {1'b0, quo_q[F-1]} + (F+1)'(last_take);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < F; i++) begin
        tag_q[i] <= '0;
      end
      tag_out_q <= '0;
    end else if (en_i) begin
      for (int i = 0; i < F; i++) begin
        tag_q[i] <= tag_prev[i];
      end
      tag_out_q <= tag_q[F-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < F; i++) begin
        rem_q[i] <= rem_d[i];
        quo_q[i] <= quo_d[i];
      end
      t_q <= t_d;
    end
  end

  assign tag_o = tag_out_q;
  assign t_o   = t_q;

endmodule

// ----- sv/s2rgb_cmap.sv -----
// Three-stage colour map: segment select, scale and round, hot-map reciprocal divide.
module s2rgb_cmap import s2rgb_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  s2rgb_mode_e             mode_i,
  input  s2rgb_tag_t              tag_i,
  input  logic [FRACTION_BITS:0]  t_i,
  output s2rgb_tag_t              tag_o,
  output logic [7:0]              chan_o [NUM_CHAN]
);

  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned EW = F + 4;
  localparam int unsigned VW = F + 10;
  localparam int unsigned PW = VW + 10;
  localparam int unsigned ZW = HOT_Z_WIDTH;
  localparam int unsigned MW = HOT_Z_WIDTH + HOT_RECIP_WIDTH;
  localparam int unsigned QW = MW - HOT_SHIFT;

  localparam logic [EW-1:0] JetT1   = EW'(1) << F;
  localparam logic [EW-1:0] JetT3   = EW'(3) << F;
  localparam logic [EW-1:0] JetT5   = EW'(5) << F;
  localparam logic [EW-1:0] JetT7   = EW'(7) << F;
  localparam logic [EW-1:0] JetT9   = EW'(9) << F;
  localparam logic [VW-1:0] HotB1   = VW'(333) << F;
  localparam logic [VW-1:0] HotB2   = VW'(667) << F;
  localparam logic [PW-1:0] LinBias = PW'(1) << F;
  localparam logic [PW-1:0] HotBias = PW'(333) << F;

  // LIN: round(255 * v / 2T); HOT: round(255 * x / 333T)
  typedef enum logic [1:0] {
    K_ZERO,
    K_FULL,
    K_LIN,
    K_HOT
  } kind_e;

  logic [EW-1:0] e;
  logic [VW-1:0] k;
  kind_e         kind_a [NUM_CHAN];
  logic [VW-1:0] val_a  [NUM_CHAN];

  kind_e         kind_q1 [NUM_CHAN];
  logic [VW-1:0] val_q1  [NUM_CHAN];
  kind_e         kind_q2 [NUM_CHAN];
  logic [ZW-1:0] z_q2    [NUM_CHAN];
  kind_e         kind_q3 [NUM_CHAN];
  logic [MW-1:0] prod_q3 [NUM_CHAN];
  s2rgb_tag_t    tag_q1, tag_q2, tag_q3;

  logic [PW-1:0] lin_sum [NUM_CHAN];
  logic [PW-1:0] hot_sum [NUM_CHAN];
  logic [ZW-1:0] z_d     [NUM_CHAN];
  logic [MW-1:0] prod_d  [NUM_CHAN];
  logic [QW-1:0] hot_q   [NUM_CHAN];

  always_comb begin
    e = {t_i, 3'b000};
    k = VW'(t_i) * VW'(1000);
    for (int c = 0; c < NUM_CHAN; c++) begin
      kind_a[c] = K_ZERO;
      val_a[c]  = '0;
    end
    unique case (mode_i)
      MODE_JET: begin
        priority if (e < JetT1) begin
          kind_a[CH_B] = K_LIN;  val_a[CH_B] = VW'(JetT1 + e);
        end else if (e < JetT3) begin
          kind_a[CH_G] = K_LIN;  val_a[CH_G] = VW'(e - JetT1);
          kind_a[CH_B] = K_FULL;
        end else if (e < JetT5) begin
          kind_a[CH_R] = K_LIN;  val_a[CH_R] = VW'(e - JetT3);
          kind_a[CH_G] = K_FULL;
          kind_a[CH_B] = K_LIN;  val_a[CH_B] = VW'(JetT5 - e);
        end else if (e < JetT7) begin
          kind_a[CH_R] = K_FULL;
          kind_a[CH_G] = K_LIN;  val_a[CH_G] = VW'(JetT7 - e);
        end else begin
          kind_a[CH_R] = K_LIN;  val_a[CH_R] = VW'(JetT9 - e);
        end
      end
      MODE_HOT: begin
        priority if (k < HotB1) begin
          kind_a[CH_R] = K_HOT;  val_a[CH_R] = k;
        end else if (k < HotB2) begin
          kind_a[CH_R] = K_FULL;
          kind_a[CH_G] = K_HOT;  val_a[CH_G] = k - HotB1;
        end else begin
          kind_a[CH_R] = K_FULL;
          kind_a[CH_G] = K_FULL;
          kind_a[CH_B] = K_HOT;  val_a[CH_B] = k - HotB2;
        end
      end
      default: begin
        // gray, and the unused mode code: v = 2t on the LIN path
        for (int c = 0; c < NUM_CHAN; c++) begin
          kind_a[c] = K_LIN;
          val_a[c]  = VW'({t_i, 1'b0});
        end
      end
    endcase
    if (tag_i.black) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        kind_a[c] = K_ZERO;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      lin_sum[c] = PW'(val_q1[c]) * PW'(255) + LinBias;
      hot_sum[c] = PW'(val_q1[c]) * PW'(510) + HotBias;
      z_d[c]     = (kind_q1[c] == K_HOT) ? ZW'(hot_sum[c] >> F) : ZW'(lin_sum[c] >> (F + 1));
      prod_d[c]  = (kind_q2[c] == K_HOT) ? MW'(z_q2[c]) * MW'(HOT_RECIP) : MW'(z_q2[c]);
      hot_q[c]   = QW'(prod_q3[c] >> HOT_SHIFT);
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      unique case (kind_q3[c])
        K_ZERO:  chan_o[c] = 8'h00;
        K_FULL:  chan_o[c] = 8'hFF;
        K_LIN:   chan_o[c] = prod_q3[c][7:0];
        K_HOT:   chan_o[c] = (hot_q[c] > QW'(255)) ? 8'hFF : hot_q[c][7:0];
        default: chan_o[c] = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q1 <= '0;
      tag_q2 <= '0;
      tag_q3 <= '0;
    end else if (en_i) begin
      tag_q1 <= tag_i;
      tag_q2 <= tag_q1;
      tag_q3 <= tag_q2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        kind_q1[c] <= kind_a[c];
        val_q1[c]  <= val_a[c];
        kind_q2[c] <= kind_q1[c];
        z_q2[c]    <= z_d[c];
        kind_q3[c] <= kind_q2[c];
        prod_q3[c] <= prod_d[c];
      end
    end
  end

  assign tag_o = tag_q3;

endmodule

// ----- sv/scalar_to_rgb_colormap.sv -----
// Top level: range registers, sample normalisation, divider and colour map pipeline.
//
//   channel  direction  handshake                  payload
//   in       request    in_valid_i / in_stall_o    sample_value_i
//   out      result     out_valid_o / out_stall_i  red_o, green_o, blue_o
//   cfg      write      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One request per cycle while the result is not stalled; the divider resolves
// one quotient bit per stage, plus a rounding stage.
// A stalled result freezes the whole pipeline; bubbles are not squeezed out.
// Reset clears the valid bits and loads the range and mode registers.
module scalar_to_rgb_colormap import s2rgb_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      red_o,
  output logic [7:0]                      green_o,
  output logic [7:0]                      blue_o,
  input  logic                            cfg_we_i,
  input  logic [CFG_INDEX_WIDTH-1:0]      cfg_index_i,
  input  logic [SAMPLE_WIDTH-1:0]         cfg_data_i
);

  localparam int unsigned W = SAMPLE_WIDTH;
  localparam int unsigned F = FRACTION_BITS;
  localparam logic [W-1:0] HighReset = W'(RANGE_HIGH_RESET);

  logic signed [W-1:0] range_low_q, range_high_q;
  s2rgb_mode_e         mode_q;
  logic [W-1:0]        span_q;

  logic                en;
  logic [W-1:0]        diff;
  logic                below, above, span_bad;
  s2rgb_tag_t          tag0_d, tag0_q;
  logic [W-1:0]        rem0_q;

  s2rgb_tag_t          div_tag;
  logic [F:0]          div_t;
  s2rgb_tag_t          cm_tag;
  logic [7:0]          cm_chan [NUM_CHAN];

  logic                out_valid_q;
  logic [7:0]          rgb_q [NUM_CHAN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= '0;
      range_high_q <= HighReset;
      mode_q       <= MODE_JET;
      span_q       <= HighReset;
    end else begin
      span_q <= range_high_q - range_low_q;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_RANGE_LOW:     range_low_q  <= cfg_data_i;
          REG_RANGE_HIGH:    range_high_q <= cfg_data_i;
          REG_COLORMAP_MODE: mode_q       <= s2rgb_mode_e'(cfg_data_i[1:0]);
          default: ;
        endcase
      end
    end
  end

  assign en         = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~en;

  assign diff     = sample_value_i - range_low_q;
  assign below    = sample_value_i <= range_low_q;
  assign above    = sample_value_i >= range_high_q;
  assign span_bad = range_high_q <= range_low_q;

  always_comb begin
    tag0_d.valid  = in_valid_i;
    tag0_d.black  = span_bad;
    tag0_d.sat_lo = below;
    tag0_d.sat_hi = above;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
    end else if (en) begin
      tag0_q <= tag0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem0_q <= diff;
    end
  end

  s2rgb_div #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .span_i (span_q),
    .tag_i  (tag0_q),
    .rem_i  (rem0_q),
    .tag_o  (div_tag),
    .t_o    (div_t)
  );

  s2rgb_cmap #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cmap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .mode_i (mode_q),
    .tag_i  (div_tag),
    .t_i    (div_t),
    .tag_o  (cm_tag),
    .chan_o (cm_chan)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cm_tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        rgb_q[c] <= cm_chan[c];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = rgb_q[CH_R];
  assign green_o     = rgb_q[CH_G];
  assign blue_o      = rgb_q[CH_B];

`ifndef SYNTH
  a_t_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_tag.valid |-> div_t <= ((F + 1)'(1) << F))
    else $error("fraction above one");

  a_t_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_tag.valid && div_tag.sat_lo |-> div_t == '0)
    else $error("sample below range gave nonzero fraction");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cm_tag.valid && cm_tag.black |->
      cm_chan[CH_R] == 8'h00 && cm_chan[CH_G] == 8'h00 && cm_chan[CH_B] == 8'h00)
    else $error("empty range did not give black");
`endif

endmodule

// ----- tb/scalar_to_rgb_colormap_test.sv -----
// Self-checking testbench for scalar_to_rgb_colormap: directed and random samples vs a local predictor.
`timescale 1ns / 1ps

module scalar_to_rgb_colormap_test;
  import s2rgb_pkg::*;

  localparam int unsigned SW      = SAMPLE_WIDTH_DEF;
  localparam int unsigned FB      = FRACTION_BITS_DEF;
  localparam longint      ONE     = longint'(1) << FB;
  localparam int unsigned LATENCY = FB + 6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic                           clk_i          = 1'b0;
  logic                           rst_ni         = 1'b0;
  logic                           in_valid_i     = 1'b0;
  logic                           in_stall_o;
  logic signed [SW-1:0]           sample_value_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i    = 1'b0;
  logic [7:0]                     red_o;
  logic [7:0]                     green_o;
  logic [7:0]                     blue_o;
  logic                           cfg_we_i       = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0]     cfg_index_i    = '0;
  logic [SW-1:0]                  cfg_data_i     = '0;

  logic signed [SW-1:0] range_low_q  = '0;
  logic signed [SW-1:0] range_high_q = SW'(RANGE_HIGH_RESET);
  logic [1:0]           mode_q       = MODE_JET;

  rgb_t        expected_rgb[$];
  int unsigned fail_count      = 0;
  bit          sender_gaps     = 1'b1;
  bit          receiver_stalls = 1'b1;
  int          hold_request    = 0;
  int          stall_left      = 0;

  always #5 clk_i = ~clk_i;

  scalar_to_rgb_colormap dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_value_i (sample_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // round half up, saturate to 255
  function automatic logic [7:0] chan(longint num, longint den);
    longint q;
    q = (2 * num + den) / (2 * den);
    return (q > 255) ? 8'd255 : 8'(q);
  endfunction

  function automatic rgb_t map_sample(logic signed [SW-1:0] s);
    longint span, offs, t, rem, e, k, den;
    int     i;
    rgb_t   c;
    c    = '0;
    span = longint'(range_high_q) - longint'(range_low_q);
    if (span <= 0) return c;
    offs = longint'(s) - longint'(range_low_q);
    if (offs <= 0) t = 0;
    else if (offs >= span) t = ONE;
    else begin
      rem = offs;
      t   = 0;
      for (i = 0; i < FB; i++) begin
        rem = rem << 1;
        t   = t << 1;
        if (rem >= span) begin
          rem = rem - span;
          t   = t | 1;
        end
      end
      rem = rem << 1;
      if (rem >= span) t = t + 1;
    end
    if (t > ONE) t = ONE;
    if (mode_q == MODE_JET) begin
      e = 8 * t;
      if (e < ONE) begin
        c.blue = chan(255 * (ONE + e), 2 * ONE);
      end else if (e < 3 * ONE) begin
        c.green = chan(255 * (e - ONE), 2 * ONE);
        c.blue  = 8'd255;
      end else if (e < 5 * ONE) begin
        c.red   = chan(255 * (e - 3 * ONE), 2 * ONE);
        c.green = 8'd255;
        c.blue  = chan(255 * (5 * ONE - e), 2 * ONE);
      end else if (e < 7 * ONE) begin
        c.red   = 8'd255;
        c.green = chan(255 * (7 * ONE - e), 2 * ONE);
      end else begin
        c.red = chan(255 * (9 * ONE - e), 2 * ONE);
      end
    end else if (mode_q == MODE_HOT) begin
      k   = 1000 * t;
      den = 333 * ONE;
      if (k < 333 * ONE) begin
        c.red = chan(255 * k, den);
      end else if (k < 667 * ONE) begin
        c.red   = 8'd255;
        c.green = chan(255 * (k - 333 * ONE), den);
      end else begin
        c.red   = 8'd255;
        c.green = 8'd255;
        c.blue  = chan(255 * (k - 667 * ONE), den);
      end
    end else begin
      c.red   = chan(255 * t, ONE);
      c.green = c.red;
      c.blue  = c.red;
    end
    return c;
  endfunction

  // valid stays high across back-to-back requests; lowered for a gap and by settle
  task automatic send_sample(logic signed [SW-1:0] v);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= v;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    expected_rgb.push_back(map_sample(v));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [SW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_RANGE_LOW:     range_low_q  = data;
      REG_RANGE_HIGH:    range_high_q = data;
      REG_COLORMAP_MODE: mode_q       = data[1:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    longint span, off;
    span = longint'(range_high_q) - longint'(range_low_q);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        off = longint'($urandom_range(0, 6)) - 3;
        return SW'(longint'(range_low_q) + off);
      end
      2: begin
        off = longint'($urandom_range(0, 6)) - 3;
        return SW'(longint'(range_high_q) + off);
      end
      default: begin
        if (span <= 0) return $urandom;
        off = longint'({$urandom, $urandom} % (span + 1));
        return SW'(longint'(range_low_q) + off);
      end
    endcase
  endfunction

  task automatic test_default_range();
    send_sample(S_MIN);
    send_sample(SW'(32768));
    send_sample(S_MAX);
  endtask

  task automatic test_breakpoints();
    int jet_pts [7] = '{8191, 8192, 24575, 24576, 40960, 57344, 65535};
    int hot_pts [5] = '{21823, 21824, 43712, 43713, 65536};
    settle();
    write_register(REG_RANGE_LOW, '0);
    write_register(REG_RANGE_HIGH, SW'(ONE));
    foreach (jet_pts[i]) send_sample(SW'(jet_pts[i]));
    settle();
    write_register(REG_COLORMAP_MODE, SW'(MODE_HOT));
    foreach (hot_pts[i]) send_sample(SW'(hot_pts[i]));
    settle();
    write_register(REG_COLORMAP_MODE, SW'(MODE_GRAY));
    send_sample('0);
    send_sample(SW'(32768));
    send_sample(SW'(ONE));
    settle();
    // spare mode code behaves as gray; upper data bits are dropped
    write_register(REG_COLORMAP_MODE, 32'hFFFF_FFFF);
    send_sample(SW'(32767));
  endtask

  task automatic test_degenerate_range();
    settle();
    write_register(REG_COLORMAP_MODE, SW'(MODE_JET));
    write_register(REG_RANGE_LOW, SW'(1000));
    write_register(REG_RANGE_HIGH, SW'(1000));
    send_sample(SW'(1000));
    settle();
    write_register(REG_RANGE_LOW, S_MAX);
    write_register(REG_RANGE_HIGH, S_MIN);
    send_sample('0);
  endtask

  task automatic test_extreme_range();
    settle();
    write_register(REG_RANGE_LOW, S_MIN);
    write_register(REG_RANGE_HIGH, S_MAX);
    write_register(REG_UNUSED, '1);
    send_sample(S_MIN);
    send_sample('0);
    send_sample(S_MAX);
  endtask

  task automatic test_random_traffic();
    logic signed [SW-1:0] lo, hi;
    int kind;
    for (int p = 0; p < 10; p++) begin
      settle();
      kind = (p < 5) ? p : $urandom_range(0, 4);
      lo   = $urandom;
      hi   = $urandom;
      case (kind)
        0: begin
          lo = S_MIN;
          hi = S_MAX;
        end
        1: hi = SW'(longint'(lo) + $urandom_range(1, 4096));
        3: hi = lo;
        4: begin
          lo = -SW'($urandom_range(0, 1 << 20));
          hi = SW'($urandom_range(1, 1 << 22));
        end
        default: ;
      endcase
      write_register(REG_RANGE_LOW, lo);
      write_register(REG_RANGE_HIGH, hi);
      write_register(REG_COLORMAP_MODE, {30'($urandom), 2'(p % 4)});
      if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED, $urandom);
      sender_gaps     = $urandom_range(0, 2) != 0;
      receiver_stalls = $urandom_range(0, 2) != 0;
      repeat (100) send_sample(pick_sample());
    end
  endtask

  task automatic test_backpressure();
    settle();
    write_register(REG_RANGE_LOW, -SW'(ONE));
    write_register(REG_RANGE_HIGH, SW'(ONE));
    write_register(REG_COLORMAP_MODE, SW'(MODE_JET));
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    hold_request    = 300;
    repeat (80) send_sample(pick_sample());
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // result side: random wait after each result, plus a long hold on request
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i == 1'b0)
      stall_left = receiver_stalls ? $urandom_range(0, 18) : 0;
    if (hold_request != 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk_i) begin
    rgb_t want;
    if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_rgb.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d", red_o, green_o, blue_o);
        fail_count++;
      end else begin
        want = expected_rgb.pop_front();
        if (red_o !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, red_o);
          fail_count++;
        end
        if (green_o !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, green_o);
          fail_count++;
        end
        if (blue_o !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, blue_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_range();
    test_breakpoints();
    test_degenerate_range();
    test_extreme_range();
    test_random_traffic();
    test_backpressure();
    settle();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/s2rgb_pkg.sv
sv/s2rgb_div.sv
sv/s2rgb_cmap.sv
sv/scalar_to_rgb_colormap.sv
tb/scalar_to_rgb_colormap_test.sv
